// ===== design/u2u_pkg.sv =====
// shared types and constants for the utf-8 to ucs-2 stream decoder
`timescale 1ns / 1ps
package u2u_pkg;

  typedef enum logic [1:0] {
    LEAD_ASCII = 2'd0,
    LEAD_TWO   = 2'd1,
    LEAD_THREE = 2'd2,
    LEAD_BAD   = 2'd3
  } lead_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_MALF  = 2'd2
  } status_e;

  localparam logic [7:0] MASK_TOP1 = 8'h80;
  localparam logic [7:0] MASK_TOP2 = 8'hC0;
  localparam logic [7:0] MASK_TOP3 = 8'hE0;
  localparam logic [7:0] MASK_TOP4 = 8'hF0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_summary;
    logic [1:0]  status;
    logic [15:0] char_count;
    logic        run_last;
  } out_word_t;

  // classified byte as it travels from front to back
  typedef struct packed {
    lead_e       lead;
    logic        cont_ok;
    logic [5:0]  low_bits;
    logic [3:0]  lead_bits;
    logic        last_byte;
  } item_t;

endpackage

// ===== design/utf8_to_ucs2_stream_decoder.sv =====
// a character or summary word is registered in the output slot when its byte is popped
// throughput: one byte per cycle while the output slot is free; in strict mode a last
//   byte ending a character gives two words, stalling pops until the summary is out
// the two-entry queue between classifier and decoder sets the byte acceptance
// reset: asynchronous, clears sequence state, count, halt and queue; mode is strict
`timescale 1ns / 1ps
module utf8_to_ucs2_stream_decoder #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  u2u_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output u2u_pkg::out_word_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import u2u_pkg::*;

  logic  lenient_q, lenient_d;
  item_t front_item, head_item;
  logic  q_full, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;
  assign lenient_d   = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : lenient_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lenient_q <= 1'b0;
    end else begin
      lenient_q <= lenient_d;
    end
  end

  u2u_front u_front (
    .in_word_i (in_data_i),
    .item_o    (front_item)
  );

  assign in_ready_o = !q_full;

  u2u_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_item)
  );

  u2u_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lenient_i   (lenient_q),
    .empty_i     (q_empty),
    .item_i      (head_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_data_o)
  );

endmodule

// ===== design/u2u_front.sv =====
// front end: classifies each incoming byte as lead or continuation
`timescale 1ns / 1ps
module u2u_front (
  input  u2u_pkg::in_word_t in_word_i,
  output u2u_pkg::item_t    item_o
);
  import u2u_pkg::*;

  logic [7:0] b;

  assign b = in_word_i.data_byte;

  always_comb begin
    item_o.cont_ok   = (b & MASK_TOP2) == CONT_TAG;
    item_o.low_bits  = b[5:0];
    item_o.last_byte = in_word_i.last_byte;
    priority if ((b & MASK_TOP1) == 8'h00) begin
      item_o.lead      = LEAD_ASCII;
      // ascii keeps bit six in lead_bits
      item_o.lead_bits = {3'b000, b[6]};
    end else if ((b & MASK_TOP3) == MASK_TOP2) begin
      item_o.lead      = LEAD_TWO;
      // two-byte lead keeps five payload bits, the top one sits in lead_bits
      item_o.lead_bits = {3'b000, b[4]};
    end else if ((b & MASK_TOP4) == MASK_TOP3) begin
      item_o.lead      = LEAD_THREE;
      item_o.lead_bits = b[3:0];
    end else begin
      item_o.lead      = LEAD_BAD;
      item_o.lead_bits = 4'h0;
    end
  end

endmodule

// ===== design/u2u_queue.sv =====
// two-entry queue between the byte classifier and the decode back end
`timescale 1ns / 1ps
module u2u_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  u2u_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output u2u_pkg::item_t head_o
);
  import u2u_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;
  logic        do_push, do_pop;

  assign full_o  = fill_q == 2'd2;
  assign empty_o = fill_q == 2'd0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== design/u2u_back.sv =====
// back end: sequence state, counting and result word generation
`timescale 1ns / 1ps
module u2u_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              lenient_i,
  input  logic              empty_i,
  input  u2u_pkg::item_t    item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output u2u_pkg::out_word_t out_word_o
);
  import u2u_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  logic [1:0]             need_q, need_d;
  logic [1:0]             held_q, held_d;
  logic [11:0]            part_q, part_d;
  logic [1:0]             err_q, err_d;
  logic                   halt_q, halt_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;
  logic      pend_q, pend_d;
  out_word_t pend_word_q, pend_word_d;

  logic      slot_free, go;
  logic      have, do_start;
  logic [15:0] cu, pv16;
  logic [COUNT_WIDTH-1:0] cnt_char;
  out_word_t char_word, sum_word;
  logic [1:0] st;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(logic [COUNT_WIDTH-1:0] c,
                                                      logic [1:0] inc);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, c} + {{(COUNT_WIDTH - 1){1'b0}}, inc};
    sat_add = s[COUNT_WIDTH] ? CountMax : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [15:0] shown(logic [COUNT_WIDTH-1:0] c);
    shown = (|(c >> 16)) ? 16'hFFFF : 16'(c);
  endfunction

  assign slot_free = !out_valid_q || out_ready_i;
  assign go        = !pend_q && slot_free && !empty_i;
  assign pop_o     = go;

  // decode of the head word against the held sequence state
  always_comb begin
    need_d   = need_q;
    held_d   = held_q;
    part_d   = part_q;
    err_d    = err_q;
    halt_d   = halt_q;
    cnt_d    = cnt_q;
    have     = 1'b0;
    do_start = 1'b0;
    cu       = 16'h0000;
    pv16     = {part_q[9:0], item_i.low_bits};
    cnt_char = cnt_q;
    st       = ST_OK;

    if (!halt_q) begin
      if (need_q == 2'd0) begin
        do_start = 1'b1;
      end else if (lenient_i) begin
        if (!item_i.cont_ok || err_q != 2'd0) begin
          // failed sequence counts one per held byte, then retry as a start
          cnt_d    = sat_add(cnt_d, held_q);
          need_d   = 2'd0;
          held_d   = 2'd0;
          part_d   = 12'h000;
          err_d    = 2'd0;
          do_start = 1'b1;
        end else begin
          held_d = held_q + 2'd1;
          need_d = need_q - 2'd1;
          if (need_q == 2'd1) begin
            cu     = pv16;
            need_d = 2'd0;
            held_d = 2'd0;
            part_d = 12'h000;
            err_d  = 2'd0;
            have   = 1'b1;
          end else begin
            part_d = pv16[11:0];
          end
        end
      end else begin
        if (!item_i.cont_ok) begin
          err_d = ST_MALF;
        end
        held_d = held_q + 2'd1;
        need_d = need_q - 2'd1;
        if (need_q == 2'd1) begin
          need_d = 2'd0;
          held_d = 2'd0;
          part_d = 12'h000;
          if (err_d != 2'd0) begin
            halt_d = 1'b1;
            err_d  = ST_MALF;
          end else begin
            cu    = pv16;
            err_d = 2'd0;
            have  = 1'b1;
          end
        end else begin
          part_d = pv16[11:0];
        end
      end
    end

    if (do_start) begin
      unique case (item_i.lead)
        LEAD_ASCII: begin
          cu   = {9'h000, item_i.lead_bits[0], item_i.low_bits};
          cu[6] = 1'b0;
          cu   = {10'h000, item_i.low_bits} | {9'h000, item_i.lead_bits[0], 6'h00};
          have = 1'b1;
        end
        LEAD_TWO: begin
          part_d = {7'h00, item_i.lead_bits[0], item_i.low_bits[3:0]};
          need_d = 2'd1;
          held_d = 2'd1;
          err_d  = 2'd0;
        end
        LEAD_THREE: begin
          part_d = {8'h00, item_i.lead_bits};
          need_d = 2'd2;
          held_d = 2'd1;
          err_d  = 2'd0;
        end
        default: begin
          if (lenient_i) begin
            cnt_d = sat_add(cnt_d, 2'd1);
          end else begin
            halt_d = 1'b1;
            err_d  = ST_MALF;
          end
        end
      endcase
    end

    if (have) begin
      cnt_d = sat_add(cnt_d, 2'd1);
    end
    cnt_char = cnt_d;

    if (item_i.last_byte) begin
      if (halt_d) begin
        st = ST_MALF;
      end else if (held_d != 2'd0) begin
        if (lenient_i) begin
          cnt_d = sat_add(cnt_d, held_d);
          st    = ST_OK;
        end else begin
          st = ST_TRUNC;
        end
      end else begin
        st = ST_OK;
      end
    end

    char_word.code_unit  = cu;
    char_word.is_summary = 1'b0;
    char_word.status     = ST_OK;
    char_word.char_count = shown(cnt_char);
    char_word.run_last   = !item_i.last_byte;

    sum_word.code_unit  = 16'h0000;
    sum_word.is_summary = 1'b1;
    sum_word.status     = st;
    sum_word.char_count = shown(cnt_d);
    sum_word.run_last   = 1'b1;

    if (item_i.last_byte) begin
      need_d = 2'd0;
      held_d = 2'd0;
      part_d = 12'h000;
      err_d  = 2'd0;
      cnt_d  = '0;
      halt_d = 1'b0;
    end
  end

  // output slot plus one spare for the summary that follows a character
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pend_d      = pend_q;
    pend_word_d = pend_word_q;
    if (slot_free) begin
      out_valid_d = 1'b0;
    end
    if (pend_q && slot_free) begin
      out_valid_d = 1'b1;
      out_d       = pend_word_q;
      pend_d      = 1'b0;
    end else if (go) begin
      if (have && !lenient_i) begin
        out_valid_d = 1'b1;
        out_d       = char_word;
        if (item_i.last_byte) begin
          pend_d      = 1'b1;
          pend_word_d = sum_word;
        end
      end else if (item_i.last_byte) begin
        out_valid_d = 1'b1;
        out_d       = sum_word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q      <= 2'd0;
      held_q      <= 2'd0;
      part_q      <= 12'h000;
      err_q       <= 2'd0;
      halt_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      if (go) begin
        need_q <= need_d;
        held_q <= held_d;
        part_q <= part_d;
        err_q  <= err_d;
        halt_q <= halt_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    pend_word_q <= pend_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_pend_has_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q) else $error("spare summary without a word in the slot");

  a_pend_behind_char : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (!out_q.is_summary && !out_q.run_last))
    else $error("spare summary queued behind a non-character word");

  a_summary_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_summary) |-> (out_q.run_last && out_q.code_unit == 16'h0000))
    else $error("summary word malformed");

  a_no_pop_while_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !pop_o) else $error("queue popped while a summary is waiting");

  a_seq_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> (need_q == 2'd0 && held_q == 2'd0))
    else $error("halted with an open sequence");

endmodule

// ===== tb/sv/tb_utf8_to_ucs2_stream_decoder.sv =====
// self-checking testbench for the utf-8 to ucs-2 stream decoder
`timescale 1ns / 1ps
module tb_utf8_to_ucs2_stream_decoder;
  import u2u_pkg::*;

  localparam int          COUNT_W      = 16;
  localparam int unsigned CNT_MAX      = (1 << COUNT_W) - 1;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          PHASE_ITEMS  = 100;
  localparam int          NUM_DIR      = 30;
  localparam longint      LIMIT_NS     = 2_000_000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;

  utf8_to_ucs2_stream_decoder #(
    .COUNT_WIDTH(COUNT_W)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // decoder state as the predictor sees it
  logic        lenient;
  logic [1:0]  seq_need;
  logic [1:0]  seq_held;
  logic [15:0] seq_bits;
  logic [15:0] char_total;
  logic        halted;
  status_e     seq_err;

  out_word_t decoded_words[$];
  int        mismatch_cnt = 0;
  bit        tx_idle_on   = 1'b0;
  bit        rx_idle_on   = 1'b0;
  bit        hold_req     = 1'b0;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        mode;
    logic        typed;
    logic [15:0] w_code;
    logic        w_sum;
    status_e     w_st;
    logic [15:0] w_cnt;
    logic        w_last;
  } dir_row_t;

  // data, last, mode, typed, then the typed word where one is given
  dir_row_t dir_rows [NUM_DIR] = '{
    '{8'h00, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b1, ST_OK,    16'd1, 1'b1},
    '{8'h7F, 1'b0, 1'b0, 1'b1, 16'h007F, 1'b0, ST_OK,    16'd1, 1'b1},
    '{8'hC3, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'hA9, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'hEF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0, ST_OK,    16'd3, 1'b1},
    '{8'hE2, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'h82, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b1, ST_TRUNC, 16'd3, 1'b1},
    // bad continuation cut off by the buffer end still reads as truncated
    '{8'hE2, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'h41, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b1, ST_TRUNC, 16'd0, 1'b1},
    '{8'hE2, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'h82, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'h41, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b1, ST_MALF,  16'd0, 1'b1},
    '{8'hC2, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b1, ST_MALF,  16'd0, 1'b1},
    // lenient counting: failed sequence, bad lead, pending at the end
    '{8'hE2, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'h41, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'hC2, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b1, ST_OK,    16'd4, 1'b1},
    // mode flips inside an open sequence
    '{8'hE2, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'h82, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'hAC, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    // strict halt survives a switch to lenient
    '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'h41, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b1, ST_MALF,  16'd0, 1'b1},
    // bad continuation marked in strict, then failed in lenient
    '{8'hE2, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'h82, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, ST_OK,    16'd0, 1'b0},
    '{8'h41, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b1, ST_OK,    16'd4, 1'b1}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void bump_count(input int unsigned n);
    if (char_total + n > CNT_MAX) char_total = 16'(CNT_MAX);
    else char_total = 16'(char_total + n);
  endfunction

  function automatic void drop_seq();
    seq_need = '0;
    seq_held = '0;
    seq_bits = '0;
    seq_err  = ST_OK;
  endfunction

  // take b as the first byte of a sequence
  function automatic lead_e open_seq(input logic [7:0] b);
    if ((b & MASK_TOP1) == 8'h00) return LEAD_ASCII;
    if ((b & MASK_TOP3) == MASK_TOP2) begin
      seq_bits = {11'd0, b[4:0]};
      seq_need = 2'd1;
      seq_held = 2'd1;
      seq_err  = ST_OK;
      return LEAD_TWO;
    end
    if ((b & MASK_TOP4) == MASK_TOP3) begin
      seq_bits = {12'd0, b[3:0]};
      seq_need = 2'd2;
      seq_held = 2'd1;
      seq_err  = ST_OK;
      return LEAD_THREE;
    end
    return LEAD_BAD;
  endfunction

  task automatic decode_byte(input in_word_t w);
    logic [7:0]  b;
    lead_e       kind;
    logic        have;
    logic [15:0] cu;
    status_e     st;
    b    = w.data_byte;
    have = 1'b0;
    cu   = {8'h00, b};
    if (!halted) begin
      if (seq_need == 2'd0) begin
        kind = open_seq(b);
        have = (kind == LEAD_ASCII);
        if (kind == LEAD_BAD) begin
          if (lenient) begin
            bump_count(1);
          end else begin
            halted  = 1'b1;
            seq_err = ST_MALF;
          end
        end
      end else if (lenient && ((b & MASK_TOP2) != CONT_TAG || seq_err != ST_OK)) begin
        // held bytes count one each, this byte starts afresh
        bump_count(seq_held);
        drop_seq();
        kind = open_seq(b);
        have = (kind == LEAD_ASCII);
        if (kind == LEAD_BAD) bump_count(1);
      end else begin
        if ((b & MASK_TOP2) != CONT_TAG) seq_err = ST_MALF;
        seq_bits = {seq_bits[9:0], b[5:0]};
        seq_held = seq_held + 2'd1;
        seq_need = seq_need - 2'd1;
        if (seq_need != 2'd0) begin
          seq_bits[15:12] = 4'h0;
        end else if (seq_err != ST_OK) begin
          drop_seq();
          halted  = 1'b1;
          seq_err = ST_MALF;
        end else begin
          cu = seq_bits;
          drop_seq();
          have = 1'b1;
        end
      end
    end
    if (have) begin
      bump_count(1);
      if (!lenient)
        decoded_words.push_back('{code_unit: cu, is_summary: 1'b0, status: ST_OK,
                                  char_count: char_total, run_last: !w.last_byte});
    end
    if (w.last_byte) begin
      if (halted) begin
        st = ST_MALF;
      end else if (seq_held != 2'd0) begin
        if (lenient) begin
          bump_count(seq_held);
          st = ST_OK;
        end else begin
          st = ST_TRUNC;
        end
      end else begin
        st = ST_OK;
      end
      decoded_words.push_back('{code_unit: 16'h0000, is_summary: 1'b1, status: st,
                                char_count: char_total, run_last: 1'b1});
      drop_seq();
      char_total = '0;
      halted     = 1'b0;
    end
  endtask

  function automatic in_word_t as_word(input logic [7:0] b);
    return '{data_byte: b, last_byte: 1'b0};
  endfunction

  // mostly well-formed characters, with malformed ones in about half the buffers
  task automatic gen_buffer(ref in_word_t q[$]);
    int unsigned nchars;
    int unsigned kind;
    bit          clean;
    logic [7:0]  junk;
    nchars = $urandom_range(1, 8);
    clean  = $urandom_range(0, 1);
    repeat (nchars) begin
      kind = clean ? $urandom_range(0, 11) : $urandom_range(0, 15);
      junk = $urandom_range(0, 255);
      if (junk[7:6] == 2'b10) junk[6] = 1'b1;
      case (kind)
        0, 1, 2, 3, 4, 5: begin
          q.push_back(as_word({1'b0, 7'($urandom)}));
        end
        6, 7, 8: begin
          q.push_back(as_word({3'b110, 5'($urandom)}));
          q.push_back(as_word({2'b10, 6'($urandom)}));
        end
        9, 10, 11: begin
          q.push_back(as_word({4'b1110, 4'($urandom)}));
          q.push_back(as_word({2'b10, 6'($urandom)}));
          q.push_back(as_word({2'b10, 6'($urandom)}));
        end
        12: begin
          q.push_back(as_word(8'($urandom)));
        end
        13: begin
          if ($urandom_range(0, 1)) q.push_back(as_word({3'b110, 5'($urandom)}));
          else q.push_back(as_word({4'b1110, 4'($urandom)}));
        end
        14: begin
          q.push_back(as_word({4'b1110, 4'($urandom)}));
          q.push_back(as_word(junk));
          q.push_back(as_word({2'b10, 6'($urandom)}));
        end
        default: begin
          q.push_back(as_word({3'b110, 5'($urandom)}));
          q.push_back(as_word(junk));
        end
      endcase
    end
    q[q.size() - 1].last_byte = 1'b1;
  endtask

  task automatic send_byte(input in_word_t w);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(w);
  endtask

  // stop sending and let the pipeline empty, bytes with no word included
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (decoded_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lenient = m;
  endtask

  task automatic run_phase(input logic mode, input bit idling, input bit squeeze);
    in_word_t stream[$];
    drain_block();
    if (mode != lenient) write_mode(mode);
    tx_idle_on = idling;
    rx_idle_on = idling;
    while (stream.size() < PHASE_ITEMS) gen_buffer(stream);
    // cut mid-buffer so the next mode picks up an open buffer
    while (stream.size() > PHASE_ITEMS) void'(stream.pop_back());
    foreach (stream[i]) begin
      if (squeeze && i == 20) hold_req = 1'b1;
      send_byte(stream[i]);
    end
  endtask

  initial begin : rx_pacing
    int unsigned stall;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(1, 6);
        repeat (stall - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic report_word(input string what, input out_word_t want, input out_word_t got);
    if (mismatch_cnt < 10) begin
      $write("%0t %s: want code=%h sum=%b st=%0d cnt=%0d last=%b",
             $realtime, what, want.code_unit, want.is_summary, want.status,
             want.char_count, want.run_last);
      $display("  got code=%h sum=%b st=%0d cnt=%0d last=%b",
               got.code_unit, got.is_summary, got.status, got.char_count, got.run_last);
    end
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin : word_check
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_words.size() == 0) begin
        report_word("unexpected word", '0, out_data_o);
      end else begin
        want = decoded_words.pop_front();
        if (out_data_o.code_unit  !== want.code_unit  ||
            out_data_o.is_summary !== want.is_summary ||
            out_data_o.status     !== want.status     ||
            out_data_o.char_count !== want.char_count ||
            out_data_o.run_last   !== want.run_last)
          report_word("word mismatch", want, out_data_o);
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    lenient     = 1'b0;
    drop_seq();
    char_total  = '0;
    halted      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != lenient) begin
        drain_block();
        write_mode(dir_rows[i].mode);
      end
      send_byte('{data_byte: dir_rows[i].data, last_byte: dir_rows[i].last});
      if (dir_rows[i].typed) begin
        void'(decoded_words.pop_back());
        decoded_words.push_back('{code_unit: dir_rows[i].w_code, is_summary: dir_rows[i].w_sum,
                                  status: dir_rows[i].w_st, char_count: dir_rows[i].w_cnt,
                                  run_last: dir_rows[i].w_last});
      end
    end

    for (int ph = 0; ph < 5; ph++)
      run_phase((ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1)),
                ph != 3, ph == 2);

    run_phase(1'($urandom_range(0, 1)), 1'b0, 1'b0);

    drain_block();
    if (mismatch_cnt == 0 && decoded_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
